// ===== hw/rtl/fisp_pkg.sv =====
// ----------------------------------------------------------------------------
// fisp_pkg
// Types and constants shared by the floppy image sector parser.
// ----------------------------------------------------------------------------
package fisp_pkg;

  typedef enum logic [10:0] {
    PH_COMMENT = 11'b000_0000_0001,
    PH_MODE    = 11'b000_0000_0010,
    PH_CYL     = 11'b000_0000_0100,
    PH_HEAD    = 11'b000_0000_1000,
    PH_COUNT   = 11'b000_0001_0000,
    PH_SIZE    = 11'b000_0010_0000,
    PH_MAP     = 11'b000_0100_0000,
    PH_RECORD  = 11'b000_1000_0000,
    PH_FILL    = 11'b001_0000_0000,
    PH_DATA    = 11'b010_0000_0000,
    PH_HALT    = 11'b100_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_CRC    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_HEAD    = 2'd0,
    ERR_COUNT   = 2'd1,
    ERR_SIZE    = 2'd2,
    ERR_MISSING = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    REG_MAX_SECTORS = 3'd0,
    REG_SEED_MFM_N  = 3'd1,
    REG_SEED_MFM_D  = 3'd2,
    REG_SEED_FM_N   = 3'd3,
    REG_SEED_FM_D   = 3'd4
  } reg_e;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0]  EocMark = 8'h1A;

  // controller -> datapath
  typedef struct packed {
    logic       take_mode;
    logic       take_cyl;
    logic       take_head;
    logic       take_count;
    logic       take_size;
    logic       map_wr;
    logic       map_clr;
    logic       map_inc;
    logic       take_record;
    logic       crc_step;
    logic       bytes_dec;
    logic       bytes_clr;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic        mfm;
    logic        side;
    logic        deleted;
    logic        compressed;
    logic [5:0]  track;
    logic [1:0]  size_code;
    logic [4:0]  sectors;
    logic [4:0]  map_index;
    logic [10:0] bytes_left;
    logic [10:0] sec_len;
    logic [15:0] crc;
  } dp_stat_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/floppy_image_sector_parser.sv =====
// ----------------------------------------------------------------------------
// floppy_image_sector_parser
// Track/sector parser for an image byte stream with CRC-16 per sector.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        input      in_valid_i/in_stall_o   in_byte_i
// out       output     out_valid_o/out_stall_i kind_o .. last_o
// cfg       input      cfg_we_i                cfg_idx_i, cfg_data_i
// A byte with no result is taken without a stall; one with a result is held.
// A plain data byte ending a sector gives its data result, then the trailer.
// A fill byte gives its data result, runs a one-byte-a-cycle CRC loop over
// the sector length, then gives the trailer.
// Input stalls while a result is held or a trailer or fill run is pending.
// After reset the parser skips the comment up to the 0x1A mark.
module floppy_image_sector_parser #(
  parameter int MAP_DEPTH        = 16,
  parameter int MAX_SECTOR_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic        mfm_o,
  output logic        side_o,
  output logic        deleted_o,
  output logic [4:0]  sector_number_o,
  output logic [5:0]  track_o,
  output logic [1:0]  size_code_o,
  output logic [7:0]  data_value_o,
  output logic [10:0] run_length_o,
  output logic [15:0] crc_value_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  logic [4:0]  max_q;
  logic [15:0] smn_q, smd_q, sfn_q, sfd_q, seed;
  fisp_pkg::dp_cmd_t  cmd;
  fisp_pkg::dp_stat_t stat;
  logic [4:0] sector;
  logic       byte_sel;
  logic [7:0] fill_byte, dp_byte, mf1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 5'd10;
      smn_q <= 16'hE295;
      smd_q <= 16'hD2F6;
      sfn_q <= 16'hBF84;
      sfd_q <= 16'h8FE7;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fisp_pkg::REG_MAX_SECTORS: max_q <= cfg_data_i[4:0];
        fisp_pkg::REG_SEED_MFM_N:  smn_q <= cfg_data_i;
        fisp_pkg::REG_SEED_MFM_D:  smd_q <= cfg_data_i;
        fisp_pkg::REG_SEED_FM_N:   sfn_q <= cfg_data_i;
        fisp_pkg::REG_SEED_FM_D:   sfd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign mf1     = in_byte_i - 8'd1;
  assign seed    = stat.mfm ? (mf1[1] ? smd_q : smn_q) : (mf1[1] ? sfd_q : sfn_q);
  assign dp_byte = byte_sel ? fill_byte : in_byte_i;

  fisp_dp #(.MapDepth(MAP_DEPTH)) u_dp (
    .clk_i, .rst_ni, .byte_i(dp_byte), .seed_i(seed), .cmd_i(cmd),
    .stat_o(stat), .sector_o(sector)
  );

  fisp_ctrl #(.MapDepth(MAP_DEPTH), .MaxSectorBytes(MAX_SECTOR_BYTES)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_byte_i,
    .max_sectors_i(max_q), .stat_i(stat), .sector_i(sector), .cmd_o(cmd),
    .byte_sel_o(byte_sel), .fill_byte_o(fill_byte),
    .out_valid_o, .out_stall_i, .kind_o, .mfm_o, .side_o, .deleted_o,
    .sector_number_o, .track_o, .size_code_o, .data_value_o, .run_length_o,
    .crc_value_o, .status_o, .last_o
  );

`ifndef SYNTH
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == fisp_pkg::KIND_ERROR |-> last_o)
    else $error("error result without last");
  a_crc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == fisp_pkg::KIND_CRC |-> last_o)
    else $error("crc trailer without last");
  a_hdr_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == fisp_pkg::KIND_HEADER |-> last_o && run_length_o == '0)
    else $error("malformed header");
`endif

endmodule

// ===== hw/rtl/fisp_dp.sv =====
// ----------------------------------------------------------------------------
// fisp_dp
// Track and sector registers, sector map, byte counter and CRC register.
// ----------------------------------------------------------------------------
module fisp_dp #(
  parameter int MapDepth = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         byte_i,
  input  logic [15:0]        seed_i,
  input  fisp_pkg::dp_cmd_t  cmd_i,
  output fisp_pkg::dp_stat_t stat_o,
  output logic [4:0]         sector_o
);

  localparam int MapAw = (MapDepth > 1) ? $clog2(MapDepth) : 1;

  logic        mfm_q, side_q, del_q, comp_q;
  logic [5:0]  track_q;
  logic [1:0]  size_q;
  logic [4:0]  sectors_q, idx_q;
  logic [10:0] bytes_q;
  logic [15:0] crc_q;
  logic [4:0]  map_q [MapDepth];
  logic [7:0]  rec_m1;

  assign rec_m1 = byte_i - 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mfm_q     <= 1'b0;
      side_q    <= 1'b0;
      del_q     <= 1'b0;
      comp_q    <= 1'b0;
      track_q   <= '0;
      size_q    <= '0;
      sectors_q <= '0;
      idx_q     <= '0;
      bytes_q   <= '0;
      crc_q     <= '0;
    end else begin
      if (cmd_i.take_mode) mfm_q <= (byte_i > 8'd2);
      if (cmd_i.take_cyl) track_q <= byte_i[5:0];
      if (cmd_i.take_head) side_q <= byte_i[0];
      if (cmd_i.take_count) sectors_q <= byte_i[4:0];
      if (cmd_i.take_size) size_q <= byte_i[1:0];
      if (cmd_i.map_clr) idx_q <= '0;
      else if (cmd_i.map_inc) idx_q <= idx_q + 5'd1;
      if (cmd_i.take_record) begin
        comp_q  <= rec_m1[0];
        del_q   <= rec_m1[1];
        crc_q   <= seed_i;
        bytes_q <= stat_o.sec_len;
      end else begin
        if (cmd_i.crc_step) crc_q <= fisp_pkg::crc_byte(crc_q, byte_i);
        if (cmd_i.bytes_clr) bytes_q <= '0;
        else if (cmd_i.bytes_dec && bytes_q != '0) bytes_q <= bytes_q - 11'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_wr && 32'(idx_q) < MapDepth) map_q[idx_q[MapAw-1:0]] <= byte_i[4:0];
  end

  assign sector_o = (32'(idx_q) < MapDepth) ? map_q[idx_q[MapAw-1:0]] : 5'd0;

  always_comb begin
    stat_o.mfm        = mfm_q;
    stat_o.side       = side_q;
    stat_o.deleted    = del_q;
    stat_o.compressed = comp_q;
    stat_o.track      = track_q;
    stat_o.size_code  = size_q;
    stat_o.sectors    = sectors_q;
    stat_o.map_index  = idx_q;
    stat_o.bytes_left = bytes_q;
    stat_o.sec_len    = 11'd128 << size_q;
    stat_o.crc        = crc_q;
  end

endmodule

// ===== hw/rtl/fisp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fisp_ctrl
// Parse sequencer, fill-run CRC loop and result buffer.
// ----------------------------------------------------------------------------
module fisp_ctrl #(
  parameter int MapDepth       = 16,
  parameter int MaxSectorBytes = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic [4:0]         max_sectors_i,
  input  fisp_pkg::dp_stat_t stat_i,
  input  logic [4:0]         sector_i,
  output fisp_pkg::dp_cmd_t  cmd_o,
  output logic               byte_sel_o,
  output logic [7:0]         fill_byte_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic               mfm_o,
  output logic               side_o,
  output logic               deleted_o,
  output logic [4:0]         sector_number_o,
  output logic [5:0]         track_o,
  output logic [1:0]         size_code_o,
  output logic [7:0]         data_value_o,
  output logic [10:0]        run_length_o,
  output logic [15:0]        crc_value_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic        mfm;
    logic        side;
    logic        deleted;
    logic [4:0]  sector;
    logic [5:0]  track;
    logic [1:0]  size_code;
    logic [7:0]  value;
    logic [10:0] run;
    logic [15:0] crc;
    logic [1:0]  status;
    logic        last;
  } res_t;

  fisp_pkg::phase_e phase_q, phase_d;
  logic        ov_q, ov_d;
  res_t        res_q, res_d;
  logic        pend_q, pend_d;   // crc trailer waits
  logic        busy_q, busy_d;   // fill run in progress
  logic [10:0] cnt_q, cnt_d;
  logic [7:0]  fill_q, fill_d;
  logic        acc, fire, nxt_mode;
  res_t        ctx;

  assign in_stall_o  = ov_q || pend_q || busy_q;
  assign acc         = in_valid_i && !in_stall_o;
  assign fire        = ov_q && !out_stall_i;
  assign byte_sel_o  = busy_q;
  assign fill_byte_o = fill_q;
  assign nxt_mode    = (stat_i.map_index + 5'd1) >= stat_i.sectors;

  always_comb begin
    ctx = '0;
    ctx.mfm = stat_i.mfm;
    ctx.side = stat_i.side;
    ctx.deleted = stat_i.deleted;
    ctx.sector = sector_i;
    ctx.track = stat_i.track;
    ctx.size_code = stat_i.size_code;
  end

  always_comb begin
    phase_d = phase_q;
    ov_d    = ov_q && out_stall_i;
    res_d   = res_q;
    pend_d  = pend_q;
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    fill_d  = fill_q;
    cmd_o   = '0;
    if (busy_q) begin
      cmd_o.crc_step = 1'b1;
      cnt_d = cnt_q - 11'd1;
      if (cnt_q == 11'd1) begin
        busy_d = 1'b0;
        pend_d = 1'b1;
        cmd_o.map_inc = 1'b1;
        cmd_o.bytes_clr = 1'b1;
      end
    end else if (pend_q && !ov_d) begin
      // trailer: map index already advanced, so send context captured earlier
      pend_d = 1'b0;
      ov_d   = 1'b1;
      res_d.kind = fisp_pkg::KIND_CRC;
      res_d.value = '0;
      res_d.run = '0;
      res_d.crc = stat_i.crc;
      res_d.status = '0;
      res_d.last = 1'b1;
      phase_d = (stat_i.map_index >= stat_i.sectors) ? fisp_pkg::PH_MODE
                                                     : fisp_pkg::PH_RECORD;
    end else if (acc) begin
      unique case (phase_q)
        fisp_pkg::PH_COMMENT: if (in_byte_i == fisp_pkg::EocMark) phase_d = fisp_pkg::PH_MODE;
        fisp_pkg::PH_MODE: begin
          cmd_o.take_mode = 1'b1;
          phase_d = fisp_pkg::PH_CYL;
        end
        fisp_pkg::PH_CYL: begin
          cmd_o.take_cyl = 1'b1;
          phase_d = fisp_pkg::PH_HEAD;
        end
        fisp_pkg::PH_HEAD: begin
          if (in_byte_i > 8'd1) begin
            res_d = '0;
            res_d.kind = fisp_pkg::KIND_ERROR;
            res_d.status = fisp_pkg::ERR_HEAD;
            res_d.last = 1'b1;
            ov_d = 1'b1;
            phase_d = fisp_pkg::PH_HALT;
          end else begin
            cmd_o.take_head = 1'b1;
            phase_d = fisp_pkg::PH_COUNT;
          end
        end
        fisp_pkg::PH_COUNT: begin
          if (in_byte_i > {3'b000, max_sectors_i} || 32'(in_byte_i) > MapDepth) begin
            res_d = '0;
            res_d.kind = fisp_pkg::KIND_ERROR;
            res_d.status = fisp_pkg::ERR_COUNT;
            res_d.last = 1'b1;
            ov_d = 1'b1;
            phase_d = fisp_pkg::PH_HALT;
          end else begin
            cmd_o.take_count = 1'b1;
            phase_d = fisp_pkg::PH_SIZE;
          end
        end
        fisp_pkg::PH_SIZE: begin
          if (in_byte_i > 8'd3 || (32'd128 << in_byte_i[1:0]) > MaxSectorBytes) begin
            res_d = '0;
            res_d.kind = fisp_pkg::KIND_ERROR;
            res_d.status = fisp_pkg::ERR_SIZE;
            res_d.last = 1'b1;
            ov_d = 1'b1;
            phase_d = fisp_pkg::PH_HALT;
          end else begin
            cmd_o.take_size = 1'b1;
            cmd_o.map_clr = 1'b1;
            phase_d = (stat_i.sectors == '0) ? fisp_pkg::PH_MODE : fisp_pkg::PH_MAP;
          end
        end
        fisp_pkg::PH_MAP: begin
          cmd_o.map_wr = 1'b1;
          if (nxt_mode) begin
            cmd_o.map_clr = 1'b1;
            phase_d = fisp_pkg::PH_RECORD;
          end else begin
            cmd_o.map_inc = 1'b1;
          end
        end
        fisp_pkg::PH_RECORD: begin
          if (in_byte_i == 8'd0) begin
            res_d = '0;
            res_d.kind = fisp_pkg::KIND_ERROR;
            res_d.status = fisp_pkg::ERR_MISSING;
            res_d.last = 1'b1;
            ov_d = 1'b1;
            phase_d = fisp_pkg::PH_HALT;
          end else begin
            cmd_o.take_record = 1'b1;
            res_d = ctx;
            res_d.kind = fisp_pkg::KIND_HEADER;
            res_d.deleted = in_byte_i[1] ^ (in_byte_i[0] == 1'b0);
            res_d.status = {1'b0, in_byte_i > 8'd4};
            res_d.last = 1'b1;
            ov_d = 1'b1;
            phase_d = (in_byte_i[0] == 1'b0) ? fisp_pkg::PH_FILL : fisp_pkg::PH_DATA;
          end
        end
        fisp_pkg::PH_FILL: begin
          res_d = ctx;
          res_d.kind = fisp_pkg::KIND_DATA;
          res_d.value = in_byte_i;
          res_d.run = stat_i.sec_len;
          res_d.last = 1'b0;
          ov_d = 1'b1;
          busy_d = 1'b1;
          cnt_d = stat_i.sec_len;
          fill_d = in_byte_i;
        end
        fisp_pkg::PH_DATA: begin
          cmd_o.crc_step = 1'b1;
          cmd_o.bytes_dec = 1'b1;
          res_d = ctx;
          res_d.kind = fisp_pkg::KIND_DATA;
          res_d.value = in_byte_i;
          res_d.run = 11'd1;
          ov_d = 1'b1;
          if (stat_i.bytes_left <= 11'd1) begin
            res_d.last = 1'b0;
            pend_d = 1'b1;
            cmd_o.map_inc = 1'b1;
          end else begin
            res_d.last = 1'b1;
          end
        end
        fisp_pkg::PH_HALT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fisp_pkg::PH_COMMENT;
      ov_q    <= 1'b0;
      pend_q  <= 1'b0;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      ov_q    <= ov_d;
      pend_q  <= pend_d;
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    fill_q <= fill_d;
  end

  assign out_valid_o     = ov_q;
  assign kind_o          = res_q.kind;
  assign mfm_o           = res_q.mfm;
  assign side_o          = res_q.side;
  assign deleted_o       = res_q.deleted;
  assign sector_number_o = res_q.sector;
  assign track_o         = res_q.track;
  assign size_code_o     = res_q.size_code;
  assign data_value_o    = res_q.value;
  assign run_length_o    = res_q.run;
  assign crc_value_o     = res_q.crc;
  assign status_o        = res_q.status;
  assign last_o          = res_q.last;

  logic unused_fire;
  assign unused_fire = fire ^ stat_i.compressed;

endmodule
